// ===== src/rpn_stack_calculator_unit_macros.svh =====
// assertion macros for the rpn stack calculator
`ifndef RPN_STACK_CALCULATOR_UNIT_MACROS_SVH
`define RPN_STACK_CALCULATOR_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge out of reset
`define RPNSC_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rpnsc assertion failed");
// condition must never be true out of reset
`define RPNSC_NEVER(name, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("rpnsc forbidden condition seen");
`else
`define RPNSC_ASSERT(name, prop)
`define RPNSC_NEVER(name, cond)
`endif

`endif

// ===== src/rpnsc_pkg.sv =====
package rpnsc_pkg;

  localparam int STACK_DEPTH = 128;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  localparam logic [63:0] SIGN_MIN = 64'h8000_0000_0000_0000;
  localparam logic [63:0] POS_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef enum logic [3:0] {
    CMD_PUSH    = 4'd0,
    CMD_ADD     = 4'd1,
    CMD_SUB     = 4'd2,
    CMD_MUL     = 4'd3,
    CMD_DIV     = 4'd4,
    CMD_MOD     = 4'd5,
    CMD_PEEK    = 4'd6,
    CMD_DUP     = 4'd7,
    CMD_SWAP    = 4'd8,
    CMD_CLEAR   = 4'd9,
    CMD_POPSHOW = 4'd10
  } cmd_e_t;

  typedef enum logic [2:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV,
    ALU_MOD
  } alu_op_t;

  typedef enum logic [1:0] {
    SRC_OPV,
    SRC_A,
    SRC_B,
    SRC_RES
  } push_src_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POP_A,
    ST_CAP_A,
    ST_POP_B,
    ST_CAP_B,
    ST_CHK_B,
    ST_ARITH_GO,
    ST_ARITH_WAIT,
    ST_PUSH_RES,
    ST_PUSH_A,
    ST_PUSH_A2,
    ST_PUSH_B,
    ST_PUSH_OP,
    ST_CLEAR,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic      take;
    logic      set_bad;
    logic      pop;
    logic      cap_a;
    logic      cap_b;
    logic      push;
    push_src_t push_src;
    logic      clear;
    logic      set_dz;
    logic      arith_go;
    alu_op_t   alu_op;
    logic      load_out;
    logic      show;
  } dp_cmd_t;

  typedef struct packed {
    logic b_zero;
    logic b_int_zero;
    logic arith_done;
    logic out_hold;
  } dp_stat_t;

endpackage

// ===== src/rpnsc_arith.sv =====
module rpnsc_arith
  import rpnsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  alu_op_t     op,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] result
);

  logic         busy_r, busy_nxt;
  logic         fin_r, fin_nxt;
  logic         done_r, done_nxt;
  alu_op_t      mode_r, mode_nxt;
  logic [5:0]   step_r, step_nxt;
  logic         neg_r, neg_nxt;
  logic [63:0]  ma_r, ma_nxt;
  logic [63:0]  mb_r, mb_nxt;
  logic [127:0] acc_r, acc_nxt;
  logic [63:0]  rem_r, rem_nxt;
  logic [63:0]  nl_r, nl_nxt;
  logic [63:0]  q_r, q_nxt;
  logic [63:0]  res_r, res_nxt;

  logic [63:0]  mag_a, mag_b, sum, diff;
  logic [31:0]  ha, hb;
  logic [63:0]  prod;
  logic [127:0] prod_sh;
  logic [64:0]  rshift;
  logic [63:0]  tmod;

  function automatic logic [63:0] sat_mag(input logic neg, input logic [63:0] mag,
                                          input logic too_big);
    logic [63:0] v;
    if (neg) begin
      v = (too_big || mag > SIGN_MIN) ? SIGN_MIN : (64'd0 - mag);
    end else begin
      v = (too_big || mag[63]) ? POS_MAX : mag;
    end
    return v;
  endfunction

  assign mag_a = a[63] ? (64'd0 - a) : a;
  assign mag_b = b[63] ? (64'd0 - b) : b;
  assign sum   = a + b;
  assign diff  = a - b;

  // one 32x32 partial product per cycle
  assign ha   = step_r[1] ? ma_r[63:32] : ma_r[31:0];
  assign hb   = step_r[0] ? mb_r[63:32] : mb_r[31:0];
  assign prod = {32'd0, ha} * {32'd0, hb};

  always_comb begin
    case (step_r[1:0])
      2'd0:    prod_sh = {64'd0, prod};
      2'd3:    prod_sh = {prod, 64'd0};
      default: prod_sh = {32'd0, prod, 32'd0};
    endcase
  end

  assign rshift = {rem_r, nl_r[63]};
  assign tmod   = {rem_r[31:0], 32'd0};

  always_comb begin
    busy_nxt = busy_r;
    fin_nxt  = 1'b0;
    done_nxt = 1'b0;
    mode_nxt = mode_r;
    step_nxt = step_r;
    neg_nxt  = neg_r;
    ma_nxt   = ma_r;
    mb_nxt   = mb_r;
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    nl_nxt   = nl_r;
    q_nxt    = q_r;
    res_nxt  = res_r;
    if (start) begin
      mode_nxt = op;
      step_nxt = 6'd0;
      neg_nxt  = a[63] ^ b[63];
      ma_nxt   = mag_a;
      mb_nxt   = mag_b;
      acc_nxt  = '0;
      q_nxt    = '0;
      case (op)
        ALU_ADD: begin
          if (!(a[63] ^ b[63]) && (a[63] ^ sum[63])) begin
            res_nxt = a[63] ? SIGN_MIN : POS_MAX;
          end else begin
            res_nxt = sum;
          end
          done_nxt = 1'b1;
        end
        ALU_SUB: begin
          if ((a[63] ^ b[63]) && (a[63] ^ diff[63])) begin
            res_nxt = a[63] ? SIGN_MIN : POS_MAX;
          end else begin
            res_nxt = diff;
          end
          done_nxt = 1'b1;
        end
        ALU_MUL: begin
          busy_nxt = 1'b1;
        end
        ALU_DIV: begin
          rem_nxt = {32'd0, mag_a[63:32]};
          nl_nxt  = {mag_a[31:0], 32'd0};
          if ({32'd0, mag_a[63:32]} >= mag_b) begin
            res_nxt  = sat_mag(a[63] ^ b[63], 64'd0, 1'b1);
            done_nxt = 1'b1;
          end else begin
            busy_nxt = 1'b1;
          end
        end
        default: begin
          // integer remainder of truncated magnitudes, sign from dividend
          neg_nxt  = a[63];
          rem_nxt  = '0;
          nl_nxt   = {32'd0, mag_a[63:32]};
          mb_nxt   = {32'd0, mag_b[63:32]};
          busy_nxt = 1'b1;
        end
      endcase
    end else if (busy_r) begin
      step_nxt = step_r + 6'd1;
      if (mode_r == ALU_MUL) begin
        acc_nxt = acc_r + prod_sh;
        if (step_r[1:0] == 2'd3) begin
          busy_nxt = 1'b0;
          fin_nxt  = 1'b1;
        end
      end else begin
        nl_nxt = {nl_r[62:0], 1'b0};
        if (rshift >= {1'b0, mb_r}) begin
          rem_nxt = 64'(rshift - {1'b0, mb_r});
          q_nxt   = {q_r[62:0], 1'b1};
        end else begin
          rem_nxt = rshift[63:0];
          q_nxt   = {q_r[62:0], 1'b0};
        end
        if (step_r == 6'd63) begin
          busy_nxt = 1'b0;
          fin_nxt  = 1'b1;
        end
      end
    end else if (fin_r) begin
      done_nxt = 1'b1;
      case (mode_r)
        ALU_MUL: res_nxt = sat_mag(neg_r, acc_r[95:32], acc_r[127:96] != 32'd0);
        ALU_DIV: res_nxt = sat_mag(neg_r, q_r, 1'b0);
        default: res_nxt = neg_r ? (64'd0 - tmod) : tmod;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      mode_r <= ALU_ADD;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      fin_r  <= fin_nxt;
      done_r <= done_nxt;
      mode_r <= mode_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r <= neg_nxt;
    ma_r  <= ma_nxt;
    mb_r  <= mb_nxt;
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
    nl_r  <= nl_nxt;
    q_r   <= q_nxt;
    res_r <= res_nxt;
  end

  assign done   = done_r;
  assign result = res_r;

endmodule

// ===== src/rpnsc_dp.sv =====
module rpnsc_dp
  import rpnsc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  input  logic signed [63:0] in_operand_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] out_shown_value,
  output logic               out_shown_valid,
  output logic               out_underflow_flag,
  output logic               out_overflow_flag,
  output logic               out_divide_zero_flag,
  output logic               out_bad_command_flag,
  output logic [7:0]         out_stack_depth
);

  logic [63:0] stack_mem [STACK_DEPTH];

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             empty_r, empty_nxt;
  logic             under_r, under_nxt;
  logic             over_r, over_nxt;
  logic             dz_r, dz_nxt;
  logic             bad_r, bad_nxt;
  logic [63:0]      opv_r, a_r, b_r, rdata_r;
  logic             oval_r, oval_nxt;
  logic [63:0]      oshow_r;
  logic             oshv_r, ound_r, oovr_r, odz_r, obad_r;
  logic [7:0]       odep_r;

  logic [CNT_W-1:0] cnt_dec;
  logic [63:0]      wdata, mag_b, arith_res;
  logic             wr_en, full, arith_done;

  rpnsc_arith u_arith (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.arith_go),
    .op     (cmd.alu_op),
    .a      (a_r),
    .b      (b_r),
    .done   (arith_done),
    .result (arith_res)
  );

  assign cnt_dec = cnt_r - CNT_W'(1);
  assign full    = cnt_r >= CNT_W'(STACK_DEPTH);
  assign wr_en   = cmd.push && !full;

  always_comb begin
    case (cmd.push_src)
      SRC_OPV: wdata = opv_r;
      SRC_A:   wdata = a_r;
      SRC_B:   wdata = b_r;
      default: wdata = arith_res;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      stack_mem[cnt_r[ADDR_W-1:0]] <= wdata;
    end
    rdata_r <= stack_mem[cnt_dec[ADDR_W-1:0]];
  end

  always_comb begin
    cnt_nxt   = cnt_r;
    empty_nxt = empty_r;
    under_nxt = under_r;
    over_nxt  = over_r;
    dz_nxt    = dz_r;
    bad_nxt   = bad_r;
    if (cmd.take) begin
      under_nxt = 1'b0;
      over_nxt  = 1'b0;
      dz_nxt    = 1'b0;
      bad_nxt   = cmd.set_bad;
    end
    if (cmd.pop) begin
      if (cnt_r == '0) begin
        empty_nxt = 1'b1;
        under_nxt = 1'b1;
      end else begin
        empty_nxt = 1'b0;
        cnt_nxt   = cnt_dec;
      end
    end
    if (cmd.push) begin
      if (full) begin
        over_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
    if (cmd.clear) begin
      cnt_nxt = '0;
    end
    if (cmd.set_dz) begin
      dz_nxt = 1'b1;
    end
  end

  always_comb begin
    oval_nxt = oval_r;
    if (cmd.load_out) begin
      oval_nxt = 1'b1;
    end else if (!out_stall) begin
      oval_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      empty_r <= 1'b0;
      under_r <= 1'b0;
      over_r  <= 1'b0;
      dz_r    <= 1'b0;
      bad_r   <= 1'b0;
      oval_r  <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      empty_r <= empty_nxt;
      under_r <= under_nxt;
      over_r  <= over_nxt;
      dz_r    <= dz_nxt;
      bad_r   <= bad_nxt;
      oval_r  <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      opv_r <= in_operand_value;
    end
    // an empty pop reads as zero
    if (cmd.cap_a) begin
      a_r <= empty_r ? 64'd0 : rdata_r;
    end
    if (cmd.cap_b) begin
      b_r <= empty_r ? 64'd0 : rdata_r;
    end
    if (cmd.load_out) begin
      oshow_r <= cmd.show ? a_r : 64'd0;
      oshv_r  <= cmd.show;
      ound_r  <= under_r;
      oovr_r  <= over_r;
      odz_r   <= dz_r;
      obad_r  <= bad_r;
      odep_r  <= 8'(cnt_r);
    end
  end

  assign mag_b = b_r[63] ? (64'd0 - b_r) : b_r;

  assign stat.b_zero     = b_r == 64'd0;
  assign stat.b_int_zero = mag_b[63:32] == 32'd0;
  assign stat.arith_done = arith_done;
  assign stat.out_hold   = oval_r && out_stall;

  assign out_valid            = oval_r;
  assign out_shown_value      = oshow_r;
  assign out_shown_valid      = oshv_r;
  assign out_underflow_flag   = ound_r;
  assign out_overflow_flag    = oovr_r;
  assign out_divide_zero_flag = odz_r;
  assign out_bad_command_flag = obad_r;
  assign out_stack_depth      = odep_r;

endmodule

// ===== src/rpnsc_ctrl.sv =====
module rpnsc_ctrl
  import rpnsc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [3:0] in_command,
  input  dp_stat_t   stat,
  output dp_cmd_t    cmd
);

  state_t     state_r, state_nxt;
  logic [3:0] cmd_r, cmd_nxt;
  logic       is_arith, dz_hit;

  assign is_arith = cmd_r == CMD_ADD || cmd_r == CMD_SUB || cmd_r == CMD_MUL ||
                    cmd_r == CMD_DIV || cmd_r == CMD_MOD;
  assign dz_hit   = (cmd_r == CMD_DIV && stat.b_zero) ||
                    (cmd_r == CMD_MOD && stat.b_int_zero);

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt = in_command;
          case (in_command)
            CMD_PUSH:    state_nxt = ST_PUSH_OP;
            CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MOD:
                         state_nxt = ST_POP_B;
            CMD_PEEK, CMD_DUP, CMD_SWAP, CMD_POPSHOW:
                         state_nxt = ST_POP_A;
            CMD_CLEAR:   state_nxt = ST_CLEAR;
            default:     state_nxt = ST_FINISH;
          endcase
        end
      end
      ST_POP_A:   state_nxt = ST_CAP_A;
      ST_POP_B:   state_nxt = ST_CAP_B;
      ST_CAP_B:   state_nxt = ST_CHK_B;
      ST_CHK_B: begin
        if (cmd_r == CMD_SWAP) begin
          state_nxt = ST_PUSH_A;
        end else if (dz_hit) begin
          state_nxt = ST_FINISH;
        end else begin
          state_nxt = ST_POP_A;
        end
      end
      ST_CAP_A: begin
        if (is_arith) begin
          state_nxt = ST_ARITH_GO;
        end else if (cmd_r == CMD_SWAP) begin
          state_nxt = ST_POP_B;
        end else if (cmd_r == CMD_POPSHOW) begin
          state_nxt = ST_FINISH;
        end else begin
          state_nxt = ST_PUSH_A;
        end
      end
      ST_ARITH_GO:   state_nxt = ST_ARITH_WAIT;
      ST_ARITH_WAIT: begin
        if (stat.arith_done) begin
          state_nxt = ST_PUSH_RES;
        end
      end
      ST_PUSH_RES:   state_nxt = ST_FINISH;
      ST_PUSH_A: begin
        if (cmd_r == CMD_DUP) begin
          state_nxt = ST_PUSH_A2;
        end else if (cmd_r == CMD_SWAP) begin
          state_nxt = ST_PUSH_B;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_PUSH_A2:    state_nxt = ST_FINISH;
      ST_PUSH_B:     state_nxt = ST_FINISH;
      ST_PUSH_OP:    state_nxt = ST_FINISH;
      ST_CLEAR:      state_nxt = ST_FINISH;
      ST_FINISH: begin
        if (!stat.out_hold) begin
          state_nxt = ST_IDLE;
        end
      end
      default:       state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.push_src = SRC_OPV;
    cmd.alu_op   = ALU_ADD;
    in_stall     = state_r != ST_IDLE;
    case (state_r)
      ST_IDLE: begin
        cmd.take    = in_valid;
        cmd.set_bad = in_command > CMD_POPSHOW;
      end
      ST_POP_A, ST_POP_B: cmd.pop   = 1'b1;
      ST_CAP_A:           cmd.cap_a = 1'b1;
      ST_CAP_B:           cmd.cap_b = 1'b1;
      ST_CHK_B:           cmd.set_dz = dz_hit && cmd_r != CMD_SWAP;
      ST_ARITH_GO: begin
        cmd.arith_go = 1'b1;
        case (cmd_r)
          CMD_SUB: cmd.alu_op = ALU_SUB;
          CMD_MUL: cmd.alu_op = ALU_MUL;
          CMD_DIV: cmd.alu_op = ALU_DIV;
          CMD_MOD: cmd.alu_op = ALU_MOD;
          default: cmd.alu_op = ALU_ADD;
        endcase
      end
      ST_PUSH_RES: begin
        cmd.push     = 1'b1;
        cmd.push_src = SRC_RES;
      end
      ST_PUSH_A, ST_PUSH_A2: begin
        cmd.push     = 1'b1;
        cmd.push_src = SRC_A;
      end
      ST_PUSH_B: begin
        cmd.push     = 1'b1;
        cmd.push_src = SRC_B;
      end
      ST_PUSH_OP: cmd.push  = 1'b1;
      ST_CLEAR:   cmd.clear = 1'b1;
      ST_FINISH: begin
        cmd.load_out = !stat.out_hold;
        cmd.show     = cmd_r == CMD_PEEK || cmd_r == CMD_POPSHOW;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cmd_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cmd_r   <= cmd_nxt;
    end
  end

endmodule

// ===== src/rpn_stack_calculator_unit.sv =====
// Reverse-polish calculator over signed Q32.32 values with a 128-entry stack held in
// on-chip memory. One request is worked at a time; each stack pop goes through a pop
// state and a capture state for the registered memory read, while a push writes directly.
// Multiply forms four 32x32 partial products through one multiplier; divide and modulo
// use the shared iterative divider that retires one quotient bit per cycle. A new
// request is taken while the previous result still waits in the output register.
`include "rpn_stack_calculator_unit_macros.svh"

module rpn_stack_calculator_unit
  import rpnsc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         in_command,
  input  logic signed [63:0] in_operand_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] out_shown_value,
  output logic               out_shown_valid,
  output logic               out_underflow_flag,
  output logic               out_overflow_flag,
  output logic               out_divide_zero_flag,
  output logic               out_bad_command_flag,
  output logic [7:0]         out_stack_depth
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  rpnsc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_command (in_command),
    .stat       (dp_stat),
    .cmd        (dp_cmd)
  );

  rpnsc_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (dp_cmd),
    .stat                 (dp_stat),
    .in_operand_value     (in_operand_value),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_shown_value      (out_shown_value),
    .out_shown_valid      (out_shown_valid),
    .out_underflow_flag   (out_underflow_flag),
    .out_overflow_flag    (out_overflow_flag),
    .out_divide_zero_flag (out_divide_zero_flag),
    .out_bad_command_flag (out_bad_command_flag),
    .out_stack_depth      (out_stack_depth)
  );

  `RPNSC_NEVER(a_pop_push, dp_cmd.pop && dp_cmd.push)
  `RPNSC_NEVER(a_load_held, dp_cmd.load_out && dp_stat.out_hold)
  `RPNSC_ASSERT(a_busy_after_take, in_valid && !in_stall |=> in_stall)

endmodule
